FILE: hw/rtl/tctd_pkg.sv
// Shared constants and codes for the tiled indexed-colour texture decoder.
// No dependencies; every other file refers to it by scoped names.
package tctd_pkg;

  // Fixed geometry of the texture format. Tile sizes are powers of two.
  localparam int unsigned MaxWidth       = 1024;
  localparam int unsigned MaxHeight      = 1024;
  localparam int unsigned PaletteDepth   = 256;
  localparam int unsigned TileRows       = 32;
  localparam int unsigned TilePixels4Bit = 128;
  localparam int unsigned TileBytes      = TilePixels4Bit / 2;

  // Field widths.
  localparam int unsigned SizeW    = 11;
  localparam int unsigned BaseW    = 10;
  localparam int unsigned AddrW    = 20;
  localparam int unsigned ColourW  = 16;
  localparam int unsigned IdxW     = $clog2(PaletteDepth);
  localparam int unsigned RowTileW = $clog2(TileRows);
  localparam int unsigned ByteW    = $clog2(TileBytes);
  localparam int unsigned CfgIdxW  = 2;

  // Input commands.
  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_TEXEL   = 1'b1
  } cmd_t;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MODE_FOUR_BIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH_PIXELS  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT_ROWS   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [SizeW-1:0] WidthReset  = SizeW'(256);
  localparam logic [SizeW-1:0] HeightReset = SizeW'(256);

endpackage

FILE: hw/rtl/tiled_clut_texture_decoder_top.sv
// Tiled indexed-colour texture decoder: palette store, tile position counters
// and a two-stage output path. Depends on tctd_pkg.
//
// Usage. The input channel (in_valid / in_stall) carries one beat per palette
// word (cmd = 0) or per texture byte (cmd = 1). A palette beat writes the
// 256 x 16 palette memory and clears the tile position counters; it gives no
// result. A texture byte beat reads one or two palette entries on the two read
// ports of the memory and yields one pixel in 8-bit mode or two in 4-bit mode
// (low nibble first). The output channel (out_valid / out_stall) carries one
// pixel per beat with its raster address, RGB888, opacity and the last-of-byte
// and frame-end marks. Configuration is written through cfg_valid / cfg_ready,
// which is always ready. The user must write configuration only while the
// decoder is idle; the block itself does not enforce this.
//
// An accepted byte is registered in the read stage with its palette words,
// then in the output register. The single output port moves one pixel a cycle,
// so one byte per cycle in 8-bit mode, while the receiver does not stall.
// Reset clears the counters and loads the register defaults; the palette holds
// no defined contents until written. When the receiver stalls, the output
// register holds its pixel, the read stage behind it still takes one more byte,
// and then in_stall rises.
module tiled_clut_texture_decoder_top (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cmd,
  input  logic [tctd_pkg::IdxW-1:0]          palette_index,
  input  logic [tctd_pkg::ColourW-1:0]       palette_color,
  input  logic [7:0]                         texture_byte,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tctd_pkg::AddrW-1:0]         pixel_address,
  output logic [7:0]                         red,
  output logic [7:0]                         green,
  output logic [7:0]                         blue,
  output logic                               opaque,
  output logic                               last_of_byte,
  output logic                               frame_end,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tctd_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [tctd_pkg::SizeW-1:0]         cfg_data
);

  localparam int unsigned SizeW = tctd_pkg::SizeW;
  localparam int unsigned BaseW = tctd_pkg::BaseW;
  localparam int unsigned AddrW = tctd_pkg::AddrW;
  localparam int unsigned ColW  = tctd_pkg::ColourW;
  localparam int unsigned ProdW = 2 * SizeW;

  localparam logic [SizeW-1:0] TilePx4   = SizeW'(tctd_pkg::TilePixels4Bit);
  localparam logic [SizeW-1:0] TilePx8   = SizeW'(tctd_pkg::TileBytes);
  localparam logic [SizeW-1:0] TileRowsS = SizeW'(tctd_pkg::TileRows);
  localparam logic [SizeW-1:0] MaxW      = SizeW'(tctd_pkg::MaxWidth);
  localparam logic [SizeW-1:0] MaxH      = SizeW'(tctd_pkg::MaxHeight);

  // ---------------------------------------------------------------- config
  logic             mode_four_bit;
  logic [SizeW-1:0] width_pixels;
  logic [SizeW-1:0] height_rows;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_four_bit <= 1'b0;
      width_pixels  <= tctd_pkg::WidthReset;
      height_rows   <= tctd_pkg::HeightReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tctd_pkg::CFG_MODE_FOUR_BIT: mode_four_bit <= cfg_data[0];
        tctd_pkg::CFG_WIDTH_PIXELS:  width_pixels  <= cfg_data;
        tctd_pkg::CFG_HEIGHT_ROWS:   height_rows   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame size: capped, rounded down to whole tiles, never zero.
  logic [SizeW-1:0] tile_px;
  logic [SizeW-1:0] w_cap, w_round, w_eff;
  logic [SizeW-1:0] h_cap, h_round, h_eff;

  always_comb begin
    tile_px = mode_four_bit ? TilePx4 : TilePx8;
    w_cap   = (width_pixels > MaxW) ? MaxW : width_pixels;
    w_round = w_cap & ~(tile_px - SizeW'(1));
    w_eff   = (w_round == '0) ? tile_px : w_round;
    h_cap   = (height_rows > MaxH) ? MaxH : height_rows;
    h_round = h_cap & ~(TileRowsS - SizeW'(1));
    h_eff   = (h_round == '0) ? TileRowsS : h_round;
  end

  // ---------------------------------------------------------------- handshakes
  logic s1_valid, s1_move;
  logic s2_valid, s2_last, s2_done;
  logic in_acc, acc_tex, acc_pal;

  assign in_acc  = in_valid && !in_stall;
  assign acc_tex = in_acc && (cmd == tctd_pkg::CMD_TEXEL);
  assign acc_pal = in_acc && (cmd == tctd_pkg::CMD_PALETTE);
  assign s2_done = s2_valid && !out_stall && s2_last;
  assign s1_move = s1_valid && (!s2_valid || s2_done);
  assign in_stall = s1_valid && !s1_move;

  // ---------------------------------------------------------------- counters
  logic [BaseW-1:0]             tile_column_base;
  logic [BaseW-1:0]             tile_row_base;
  logic [tctd_pkg::RowTileW-1:0] row_within_tile;
  logic [tctd_pkg::ByteW-1:0]    byte_within_row;

  logic [SizeW-1:0] col_step, row_step;
  logic             byte_wrap, row_wrap, col_wrap, frame_wrap;

  always_comb begin
    col_step   = SizeW'(tile_column_base) + tile_px;
    row_step   = SizeW'(tile_row_base) + TileRowsS;
    byte_wrap  = (byte_within_row == '1);
    row_wrap   = byte_wrap && (row_within_tile == '1);
    col_wrap   = row_wrap && (col_step >= w_eff);
    frame_wrap = col_wrap && (row_step >= h_eff);
  end

  always_ff @(posedge clk) begin
    if (rst || acc_pal) begin
      tile_column_base <= '0;
      tile_row_base    <= '0;
      row_within_tile  <= '0;
      byte_within_row  <= '0;
    end else if (acc_tex) begin
      byte_within_row <= byte_within_row + 1'b1;
      if (byte_wrap) begin
        row_within_tile <= row_within_tile + 1'b1;
      end
      if (row_wrap) begin
        tile_column_base <= col_wrap ? '0 : col_step[BaseW-1:0];
      end
      if (col_wrap) begin
        tile_row_base <= frame_wrap ? '0 : row_step[BaseW-1:0];
      end
    end
  end

  // Raster address of the first pixel of the byte.
  logic [SizeW-1:0] cur_row, cur_col;
  logic [ProdW-1:0] row_prod;
  logic [AddrW-1:0] cur_addr;

  always_comb begin
    cur_row  = SizeW'(tile_row_base) + SizeW'(row_within_tile);
    cur_col  = SizeW'(tile_column_base)
             + (mode_four_bit ? SizeW'({byte_within_row, 1'b0})
                              : SizeW'(byte_within_row));
    row_prod = cur_row * w_eff;
    cur_addr = row_prod[AddrW-1:0] + AddrW'(cur_col);
  end

  // ---------------------------------------------------------------- palette
  logic [ColW-1:0]           palette_mem [tctd_pkg::PaletteDepth];
  logic [tctd_pkg::IdxW-1:0] rd_idx0, rd_idx1;
  logic [ColW-1:0]           rd_word0, rd_word1;

  always_comb begin
    rd_idx0 = mode_four_bit ? {4'b0, texture_byte[3:0]} : texture_byte;
    rd_idx1 = {4'b0, texture_byte[7:4]};
  end

  always_ff @(posedge clk) begin
    if (acc_pal) begin
      palette_mem[palette_index] <= palette_color;
    end
  end

  // Both read ports look up at once: low nibble or whole byte, and high nibble.
  always_ff @(posedge clk) begin
    if (acc_tex) begin
      rd_word0 <= palette_mem[rd_idx0];
      rd_word1 <= palette_mem[rd_idx1];
    end
  end

  // ---------------------------------------------------------------- read stage
  logic             s1_four, s1_fend;
  logic [AddrW-1:0] s1_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc_tex || (s1_valid && !s1_move);
    end
  end

  always_ff @(posedge clk) begin
    if (acc_tex) begin
      s1_four <= mode_four_bit;
      s1_fend <= frame_wrap;
      s1_addr <= cur_addr;
    end
  end

  // ---------------------------------------------------------------- output stage
  logic             s2_four, s2_fend, s2_sel;
  logic [AddrW-1:0] s2_addr;
  logic [ColW-1:0]  s2_word0, s2_word1;
  logic [ColW-1:0]  out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_sel   <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
      s2_sel   <= 1'b0;
    end else if (s2_done) begin
      s2_valid <= 1'b0;
      s2_sel   <= 1'b0;
    end else if (s2_valid && !out_stall) begin
      // First pixel of a 4-bit pair has gone; show the second.
      s2_sel <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_four  <= s1_four;
      s2_fend  <= s1_fend;
      s2_addr  <= s1_addr;
      s2_word0 <= rd_word0;
      s2_word1 <= rd_word1;
    end
  end

  always_comb begin
    s2_last       = !s2_four || s2_sel;
    out_word      = s2_sel ? s2_word1 : s2_word0;
    out_valid     = s2_valid;
    pixel_address = s2_addr + AddrW'(s2_sel);
    red           = {out_word[4:0], 3'b000};
    green         = {out_word[9:5], 3'b000};
    blue          = {out_word[14:10], 3'b000};
    opaque        = (out_word != '0);
    last_of_byte  = s2_last;
    frame_end     = s2_last && s2_fend;
  end

  // ---------------------------------------------------------------- assertions
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> last_of_byte)
    else $error("frame end marked on a pixel that does not close its byte");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_byte
    |=> out_valid && last_of_byte
        && (pixel_address == $past(pixel_address) + AddrW'(1)))
    else $error("second pixel of a 4-bit byte did not follow the first");

  a_pair_even: assert property (@(posedge clk) disable iff (rst)
    out_valid && s2_four && !s2_sel |-> !pixel_address[0])
    else $error("first pixel of a 4-bit byte at an odd address");

  a_palette_clears: assert property (@(posedge clk) disable iff (rst)
    acc_pal |=> (tile_column_base == '0) && (tile_row_base == '0)
                && (row_within_tile == '0) && (byte_within_row == '0))
    else $error("palette write did not clear the tile position");

endmodule

FILE: bench/tiled_clut_texture_decoder_top_test.sv
// Self-checking bench for the tiled indexed-colour texture decoder:
// random input gaps and output stalls, with a per-pixel expectation queue
// fed by an own predictor. Depends on tctd_pkg and tiled_clut_texture_decoder_top.
module tiled_clut_texture_decoder_top_test;

  localparam logic [tctd_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int unsigned RunLimitCycles = 400000;
  localparam int unsigned SettleCycles   = 4;
  localparam int unsigned TailCycles     = 8;
  localparam int unsigned DrainLimit     = 5000;
  localparam int unsigned PrintLimit     = 40;
  localparam int unsigned FrameBytes     = tctd_pkg::TileBytes * tctd_pkg::TileRows;

  typedef struct packed {
    logic [tctd_pkg::AddrW-1:0] addr;
    logic [7:0]                 r;
    logic [7:0]                 g;
    logic [7:0]                 b;
    logic                       opq;
    logic                       last;
    logic                       fend;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_stall, cmd;
  logic [tctd_pkg::IdxW-1:0]    palette_index;
  logic [tctd_pkg::ColourW-1:0] palette_color;
  logic [7:0]                   texture_byte;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [tctd_pkg::AddrW-1:0] pixel_address;
  logic [7:0] red, green, blue;
  logic opaque, last_of_byte, frame_end;
  logic cfg_valid, cfg_ready;
  logic [tctd_pkg::CfgIdxW-1:0] cfg_index;
  logic [tctd_pkg::SizeW-1:0]   cfg_data;

  tiled_clut_texture_decoder_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .palette_index(palette_index), .palette_color(palette_color),
    .texture_byte(texture_byte),
    .out_valid(out_valid), .out_stall(out_stall), .pixel_address(pixel_address),
    .red(red), .green(green), .blue(blue), .opaque(opaque),
    .last_of_byte(last_of_byte), .frame_end(frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: palette copy, registers and tile position counters.
  logic [15:0] clut [tctd_pkg::PaletteDepth];
  bit          clut_written [tctd_pkg::PaletteDepth];
  int unsigned written_any [$];
  int unsigned written_low [$];
  bit          pred_four;
  int unsigned pred_width, pred_height;
  int unsigned col_base, row_base, tile_row, byte_pos;

  pixel_t      pending_pixels [$];
  int unsigned mismatch_count = 0;
  int unsigned pixel_count = 0;
  int unsigned stall_hold = 0;
  bit          quiet = 1'b0;

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < PrintLimit) $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  function automatic int unsigned fit_dim(input int unsigned v, input int unsigned cap,
                                          input int unsigned unit);
    int unsigned s;
    s = (v < cap) ? v : cap;
    s -= s % unit;
    return (s == 0) ? unit : s;
  endfunction

  function automatic pixel_t expand_pixel(input int unsigned idx, input int unsigned addr,
                                          input bit last, input bit fend);
    pixel_t p;
    logic [15:0] w;
    w = clut[idx % tctd_pkg::PaletteDepth];
    p.addr = addr[tctd_pkg::AddrW-1:0];
    p.r    = {w[4:0], 3'b000};
    p.g    = {w[9:5], 3'b000};
    p.b    = {w[14:10], 3'b000};
    p.opq  = (w != 16'h0000);
    p.last = last;
    p.fend = fend;
    return p;
  endfunction

  task automatic predict_beat(input logic c, input logic [7:0] idx, input logic [15:0] colr,
                              input logic [7:0] tb);
    int unsigned ppb, tile_px, w, h, addr;
    bit fend;
    if (c == tctd_pkg::CMD_PALETTE) begin
      clut[idx] = colr;
      if (!clut_written[idx]) begin
        clut_written[idx] = 1'b1;
        written_any.push_back(idx);
        if (idx < 16) written_low.push_back(idx);
      end
      col_base = 0;
      row_base = 0;
      tile_row = 0;
      byte_pos = 0;
    end else begin
      ppb     = pred_four ? 2 : 1;
      tile_px = tctd_pkg::TileBytes * ppb;
      w       = fit_dim(pred_width, tctd_pkg::MaxWidth, tile_px);
      h       = fit_dim(pred_height, tctd_pkg::MaxHeight, tctd_pkg::TileRows);
      addr    = (row_base + tile_row) * w + col_base + byte_pos * ppb;
      fend    = 1'b0;
      // Counters wrap as soon as they reach or pass their bound, so a smaller
      // size written mid-frame takes effect at the next byte.
      byte_pos++;
      if (byte_pos >= tctd_pkg::TileBytes) begin
        byte_pos = 0;
        tile_row++;
        if (tile_row >= tctd_pkg::TileRows) begin
          tile_row = 0;
          col_base += tile_px;
          if (col_base >= w) begin
            col_base = 0;
            row_base += tctd_pkg::TileRows;
            if (row_base >= h) begin
              row_base = 0;
              fend = 1'b1;
            end
          end
        end
      end
      if (pred_four) begin
        pending_pixels.push_back(expand_pixel(tb[3:0], addr, 1'b0, 1'b0));
        pending_pixels.push_back(expand_pixel(tb[7:4], addr + 1, 1'b1, fend));
      end else begin
        pending_pixels.push_back(expand_pixel(tb, addr, 1'b1, fend));
      end
    end
  endtask

  task automatic send_beat(input logic c, input logic [7:0] idx, input logic [15:0] colr,
                           input logic [7:0] tb);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd           <= c;
    palette_index <= idx;
    palette_color <= colr;
    texture_byte  <= tb;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_beat(c, idx, colr, tb);
  endtask

  task automatic send_palette(input logic [7:0] idx, input logic [15:0] colr);
    send_beat(tctd_pkg::CMD_PALETTE, idx, colr, 8'($urandom));
  endtask

  task automatic send_texel(input logic [7:0] tb);
    send_beat(tctd_pkg::CMD_TEXEL, 8'($urandom), 16'($urandom), tb);
  endtask

  // Only palette entries already written are ever looked up.
  task automatic send_random_texel();
    logic [3:0] lo, hi;
    if (pred_four) begin
      lo = 4'(written_low[$urandom_range(0, written_low.size() - 1)]);
      hi = 4'(written_low[$urandom_range(0, written_low.size() - 1)]);
      send_texel({hi, lo});
    end else begin
      send_texel(8'(written_any[$urandom_range(0, written_any.size() - 1)]));
    end
  endtask

  // Palette beats give no result, so settle waits beyond the drained queue for them to land.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tctd_pkg::CfgIdxW-1:0] idx,
                           input logic [tctd_pkg::SizeW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      tctd_pkg::CFG_MODE_FOUR_BIT: pred_four   = data[0];
      tctd_pkg::CFG_WIDTH_PIXELS:  pred_width  = data;
      tctd_pkg::CFG_HEIGHT_ROWS:   pred_height = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output side: compare each accepted beat, then draw the stall before the next one.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch($sformatf("pixel beat %0d with nothing expected, address %h",
                                pixel_count, pixel_address));
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_address !== want.addr)
          flag_mismatch($sformatf("pixel %0d address %h, want %h",
                                  pixel_count, pixel_address, want.addr));
        if (red !== want.r)
          flag_mismatch($sformatf("pixel %0d red %h, want %h", pixel_count, red, want.r));
        if (green !== want.g)
          flag_mismatch($sformatf("pixel %0d green %h, want %h", pixel_count, green, want.g));
        if (blue !== want.b)
          flag_mismatch($sformatf("pixel %0d blue %h, want %h", pixel_count, blue, want.b));
        if (opaque !== want.opq)
          flag_mismatch($sformatf("pixel %0d opaque %b, want %b",
                                  pixel_count, opaque, want.opq));
        if (last_of_byte !== want.last)
          flag_mismatch($sformatf("pixel %0d last_of_byte %b, want %b",
                                  pixel_count, last_of_byte, want.last));
        if (frame_end !== want.fend)
          flag_mismatch($sformatf("pixel %0d frame_end %b, want %b",
                                  pixel_count, frame_end, want.fend));
      end
      pixel_count++;
      stall_hold = quiet ? 0 : $urandom_range(0, 3);
    end else if (out_stall && stall_hold != 0) begin
      stall_hold--;
    end
  end

  always @(negedge clk) begin
    out_stall <= (stall_hold != 0);
  end

  // Extreme colour words, including the all-zero word and one with only bit 15 set.
  task automatic test_colour_extremes();
    send_palette(8'h00, 16'h0000);
    send_palette(8'h01, 16'h8000);
    send_palette(8'h0F, 16'h7FFF);
    send_palette(8'hF0, 16'h001F);
    send_palette(8'hFF, 16'hFFFF);
    send_palette(8'h80, 16'h03E0);
    send_palette(8'h7F, 16'h7C00);
    send_texel(8'h00);
    send_texel(8'hFF);
    send_texel(8'h80);
    send_texel(8'h7F);
    send_texel(8'h01);
    send_texel(8'h0F);
    send_texel(8'hF0);
  endtask

  // Low nibble gives the left pixel; a palette write in between restarts the position.
  task automatic test_four_bit_nibbles();
    settle();
    write_reg(tctd_pkg::CFG_MODE_FOUR_BIT, 11'd1);
    send_texel(8'h0F);
    send_texel(8'hF0);
    send_texel(8'h1F);
    send_palette(8'h01, 16'h8000);
    send_texel(8'h10);
    send_texel(8'h00);
  endtask

  // One whole frame in 4-bit mode at the smallest size, so frame end and wrap occur.
  // Zero sizes fall back to one tile in each direction.
  task automatic test_full_frames();
    settle();
    write_reg(tctd_pkg::CFG_MODE_FOUR_BIT, 11'd1);
    write_reg(tctd_pkg::CFG_WIDTH_PIXELS, 11'd0);
    write_reg(tctd_pkg::CFG_HEIGHT_ROWS, 11'd0);
    send_palette(8'($urandom_range(0, 15)), 16'($urandom));
    repeat (FrameBytes + 5) send_random_texel();
  endtask

  // Phases of mixed palette and texture beats, with settings changed while the
  // position counters are part-way through a frame.
  task automatic test_random_mix();
    int unsigned wsel [4] = '{0, 2047, 1024, 64};
    int unsigned hsel [4] = '{2047, 0, 32, 1024};
    for (int p = 0; p < 13; p++) begin
      settle();
      quiet = (p % 4 == 3);
      if (p < 4) begin
        write_reg(tctd_pkg::CFG_MODE_FOUR_BIT, 11'(p % 2));
        write_reg(tctd_pkg::CFG_WIDTH_PIXELS, 11'(wsel[p]));
        write_reg(tctd_pkg::CFG_HEIGHT_ROWS, 11'(hsel[p]));
      end else begin
        write_reg(tctd_pkg::CFG_MODE_FOUR_BIT, 11'($urandom_range(0, 1)));
        if ($urandom_range(0, 1))
          write_reg(tctd_pkg::CFG_WIDTH_PIXELS, ($urandom_range(0, 1))
                    ? 11'($urandom_range(1, 16) * 64) : 11'($urandom_range(0, 2047)));
        if ($urandom_range(0, 1))
          write_reg(tctd_pkg::CFG_HEIGHT_ROWS, ($urandom_range(0, 1))
                    ? 11'($urandom_range(1, 32) * 32) : 11'($urandom_range(0, 2047)));
        if (p == 5) write_reg(CfgSpare, 11'($urandom));
      end
      repeat (10) begin
        if ($urandom_range(0, 9) == 0)
          send_palette(8'($urandom), ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom));
        else
          send_random_texel();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    int unsigned waited;
    rst           = 1'b1;
    in_valid      = 1'b0;
    cmd           = tctd_pkg::CMD_PALETTE;
    palette_index = '0;
    palette_color = '0;
    texture_byte  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = tctd_pkg::CFG_MODE_FOUR_BIT;
    cfg_data      = '0;
    pred_four     = 1'b0;
    pred_width    = tctd_pkg::WidthReset;
    pred_height   = tctd_pkg::HeightReset;
    col_base      = 0;
    row_base      = 0;
    tile_row      = 0;
    byte_pos      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_colour_extremes();
    test_four_bit_nibbles();
    test_full_frames();
    test_random_mix();

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_pixels.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (TailCycles) @(posedge clk);
    if (pending_pixels.size() != 0)
      flag_mismatch($sformatf("%0d expected pixels never arrived", pending_pixels.size()));
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(RunLimitCycles * 4);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/tctd_pkg.sv
hw/rtl/tiled_clut_texture_decoder_top.sv
bench/tiled_clut_texture_decoder_top_test.sv
